// ===== design/mits_pkg.sv =====
package mits_pkg;

   // Number of node indices the request fields can name.
   localparam int INDEX_LIMIT = 16;

   localparam logic CMD_ADD_EDGE = 1'b0;
   localparam logic CMD_RUN      = 1'b1;

   localparam logic [4:0] NODE_COUNT_RESET = 5'd1;

   typedef struct packed {
      logic       command;
      logic [3:0] producer_index;
      logic [3:0] consumer_index;
   } req_type;

   typedef struct packed {
      logic [3:0] node_index;
      logic       is_final;
      logic       cycle_found;
      logic [4:0] ordered_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_SORT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic add_edge;
      logic run_init;
      logic count_step;
      logic sort_step;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic pick_found;
   } dp_status_type;

endpackage

// ===== design/mits_ctrl.sv =====
module mits_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_command,
   input  mits_pkg::dp_status_type status,
   output logic                    busy,
   output mits_pkg::ctrl_cmd_type  cmd
);

   mits_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mits_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         mits_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_command == mits_pkg::CMD_RUN) begin
                  cmd.run_init = 1'b1;
                  state_in     = mits_pkg::ST_COUNT;
               end else begin
                  cmd.add_edge = 1'b1;
               end
            end
         end
         mits_pkg::ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (status.scan_last) begin
               state_in = mits_pkg::ST_SORT;
            end
         end
         mits_pkg::ST_SORT: begin
            // A step that finds no ready node issues the closing status.
            cmd.sort_step = 1'b1;
            if (!status.pick_found) begin
               state_in = mits_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mits_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/mits_dp.sv =====
module mits_dp #(
   parameter int MAX_NODES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mits_pkg::req_type       req_payload,
   input  mits_pkg::ctrl_cmd_type  cmd,
   output mits_pkg::dp_status_type status,
   input  logic                    csr_valid,
   input  logic [4:0]              csr_data,
   output logic                    rsp_valid,
   output mits_pkg::rsp_type       rsp_payload
);

   localparam int DEPTH = (MAX_NODES < mits_pkg::INDEX_LIMIT) ? MAX_NODES
                                                              : mits_pkg::INDEX_LIMIT;
   localparam int IDX_W = $clog2(DEPTH);

   logic [4:0]       node_count_ff, node_count_in;
   logic [DEPTH-1:0] rows_ff [DEPTH];
   logic [DEPTH-1:0] rows_in [DEPTH];
   logic [4:0]       deg_ff [DEPTH];
   logic [4:0]       deg_in [DEPTH];
   logic [DEPTH-1:0] emitted_ff, emitted_in;
   logic [4:0]       total_ff, total_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mits_pkg::rsp_type rsp_ff, rsp_in;

   logic [4:0]       active_n;
   logic [DEPTH-1:0] active;
   logic [DEPTH-1:0] ready;
   logic [IDX_W-1:0] pick;
   logic             pick_found;
   logic             edge_ok;
   logic [IDX_W-1:0] p_idx;
   logic [IDX_W-1:0] c_idx;
   logic [DEPTH-1:0] scan_row;
   logic [DEPTH-1:0] pick_row;

   // Active node count, saturated to the store depth.
   assign active_n = (node_count_ff > 5'(DEPTH)) ? 5'(DEPTH) : node_count_ff;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         active[i] = 5'(i) < active_n;
         ready[i]  = active[i] && !emitted_ff[i] && (deg_ff[i] == 5'd0);
      end
   end

   // Lowest-index ready node.
   always_comb begin
      pick       = '0;
      pick_found = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (ready[i]) begin
            pick       = IDX_W'(i);
            pick_found = 1'b1;
         end
      end
   end

   assign p_idx   = req_payload.producer_index[IDX_W-1:0];
   assign c_idx   = req_payload.consumer_index[IDX_W-1:0];
   assign edge_ok = (5'(req_payload.producer_index) < 5'(DEPTH))
                 && (5'(req_payload.consumer_index) < 5'(DEPTH))
                 && (req_payload.producer_index != req_payload.consumer_index);

   assign scan_row = rows_ff[scan_ff] & active;
   assign pick_row = rows_ff[pick] & active;

   assign status.scan_last  = (5'(scan_ff) + 5'd1) >= active_n;
   assign status.pick_found = pick_found;

   always_comb begin
      node_count_in = node_count_ff;
      rows_in       = rows_ff;
      deg_in        = deg_ff;
      emitted_in    = emitted_ff;
      total_in      = total_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;

      if (csr_valid) begin
         node_count_in = csr_data;
      end

      if (cmd.add_edge && edge_ok) begin
         rows_in[p_idx][c_idx] = 1'b1;
      end

      if (cmd.run_init) begin
         for (int j = 0; j < DEPTH; j++) begin
            deg_in[j] = 5'd0;
         end
         emitted_in = '0;
         total_in   = 5'd0;
         scan_in    = '0;
      end

      if (cmd.count_step) begin
         for (int j = 0; j < DEPTH; j++) begin
            deg_in[j] = deg_ff[j] + 5'(scan_row[j]);
         end
         scan_in = scan_ff + IDX_W'(1);
      end

      if (cmd.sort_step) begin
         rsp_valid_in = 1'b1;
         if (pick_found) begin
            emitted_in[pick] = 1'b1;
            total_in         = total_ff + 5'd1;
            rsp_in.node_index = 4'(pick);
            for (int j = 0; j < DEPTH; j++) begin
               if (pick_row[j] && (deg_ff[j] != 5'd0)) begin
                  deg_in[j] = deg_ff[j] - 5'd1;
               end
            end
         end else begin
            rsp_in.is_final      = 1'b1;
            rsp_in.cycle_found   = total_ff < active_n;
            rsp_in.ordered_count = total_ff;
            for (int i = 0; i < DEPTH; i++) begin
               rows_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= mits_pkg::NODE_COUNT_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            rows_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rows_ff       <= rows_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      deg_ff     <= deg_in;
      emitted_ff <= emitted_in;
      total_ff   <= total_in;
      scan_ff    <= scan_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/min_index_topological_sort.sv =====
// Smallest-index-first topological sorter. Edge loads (command 0) transfer one
// per cycle while busy is low; self edges, repeated edges and edges naming a
// node beyond the store are dropped. A run command (command 1) raises busy and
// builds in-degrees one adjacency row per cycle, scanning the node count
// saturated to the store size in rows (at least one). Then one node result leaves
// per cycle in order, followed by one closing status result. The receiver
// cannot stall: each result is on rsp_payload for exactly one cycle with
// rsp_valid high and must be taken then. The edge store is cleared as the
// status result is issued.
module min_index_topological_sort #(
   parameter int MAX_NODES = 16
) (
   input  logic              clock,
   input  logic              reset,
   // Command channel: a transfer happens when start is high and busy is low.
   input  logic              start,
   output logic              busy,
   input  mits_pkg::req_type req_payload,
   // Result channel: one strobed transfer per cycle, no back-pressure.
   output logic              rsp_valid,
   output mits_pkg::rsp_type rsp_payload,
   // Node count register write port.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);

   mits_pkg::ctrl_cmd_type  cmd;
   mits_pkg::dp_status_type status;

   // The register is always writable; the user must write it only while idle, the block does not enforce this.
   assign csr_ready = 1'b1;

   mits_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_payload.command),
      .status      (status),
      .busy        (busy),
      .cmd         (cmd)
   );

   mits_dp #(
      .MAX_NODES (MAX_NODES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   // Cycles without any transfer before the run is declared hung. The slowest
   // legal stretch is a full in-degree scan plus a sender gap and a config
   // hold-off, all well under this.
   localparam int HANG_LIMIT = 2000;
   // Idle cycles allowed after the last expected result before a register
   // write or the final verdict. Edge loads take effect at their transfer and the
   // status result closes a run, so this covers any trailing work.
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ITEMS = 90;

   // Tracks the node order the sorter must emit. It keeps its own copy of the
   // held edges and of the node count, and builds the expected results of a
   // run at the moment the run command transfers.
   class topo_order_tracker;
      bit [15:0]   edge_rows [mits_pkg::INDEX_LIMIT];
      bit [4:0]    node_count;
      mits_pkg::rsp_type expected_order [$];
      int          failures;

      function new();
         foreach (edge_rows[i]) edge_rows[i] = '0;
         node_count = mits_pkg::NODE_COUNT_RESET;
         failures = 0;
      endfunction

      function void write_node_count(bit [4:0] value);
         node_count = value;
      endfunction

      function int pending();
         return expected_order.size();
      endfunction

      function void note_command(mits_pkg::req_type item);
         bit [15:0]   active;
         bit [15:0]   row;
         bit [15:0]   done;
         int unsigned deg [mits_pkg::INDEX_LIMIT];
         int          n;
         int          pick;
         int          total;
         mits_pkg::rsp_type r;
         if (item.command == mits_pkg::CMD_ADD_EDGE) begin
            // Self edges drop out; a repeated edge just sets the same bit again.
            if (item.producer_index != item.consumer_index)
               edge_rows[item.producer_index][item.consumer_index] = 1'b1;
            return;
         end
         n = (node_count > mits_pkg::INDEX_LIMIT) ? mits_pkg::INDEX_LIMIT : node_count;
         active = (n == mits_pkg::INDEX_LIMIT) ? 16'hFFFF : ((16'h1 << n) - 16'h1);
         foreach (deg[i]) deg[i] = 0;
         // Only edges between active nodes count toward the in-degrees.
         for (int i = 0; i < n; i++) begin
            row = edge_rows[i] & active;
            for (int j = 0; j < n; j++)
               if (row[j]) deg[j]++;
         end
         done = '0;
         total = 0;
         while (1) begin
            pick = -1;
            for (int i = 0; i < n; i++) begin
               if (!done[i] && deg[i] == 0) begin
                  pick = i;
                  break;
               end
            end
            if (pick < 0) break;
            done[pick] = 1'b1;
            total++;
            r = '0;
            r.node_index = 4'(pick);
            expected_order = {expected_order, r};
            row = edge_rows[pick] & active;
            for (int j = 0; j < n; j++)
               if (row[j] && deg[j] > 0) deg[j]--;
         end
         // The closing status flags a cycle when some active node never got ready.
         r = '0;
         r.is_final = 1'b1;
         r.cycle_found = (total < n);
         r.ordered_count = 5'(total);
         expected_order = {expected_order, r};
         foreach (edge_rows[i]) edge_rows[i] = '0;
      endfunction

      function void report_field(string name, int want, int got);
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         failures++;
      endfunction

      function void check_result(mits_pkg::rsp_type got);
         mits_pkg::rsp_type want;
         if (expected_order.size() == 0) begin
            $display("%0t: result with nothing expected, actual %p", $time, got);
            failures++;
            return;
         end
         want = expected_order.pop_front();
         if (got.node_index !== want.node_index)
            report_field("node_index", want.node_index, got.node_index);
         if (got.is_final !== want.is_final)
            report_field("is_final", want.is_final, got.is_final);
         if (got.cycle_found !== want.cycle_found)
            report_field("cycle_found", want.cycle_found, got.cycle_found);
         if (got.ordered_count !== want.ordered_count)
            report_field("ordered_count", want.ordered_count, got.ordered_count);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   mits_pkg::req_type req_payload = '0;
   logic       rsp_valid;
   mits_pkg::rsp_type rsp_payload;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_data = '0;

   topo_order_tracker tracker;
   int gap_pct;
   int hang_count;

   min_index_topological_sort dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   // All transfers are sampled at the rising edge, before any of this edge's
   // nonblocking updates land, so the values seen are the ones the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) tracker.note_command(req_payload);
         if (rsp_valid) tracker.check_result(rsp_payload);
         if (csr_valid && csr_ready) tracker.write_node_count(csr_data);
      end
   end

   // Hang detector: any transfer on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         hang_count <= 0;
      end else begin
         hang_count <= hang_count + 1;
         if (hang_count >= HANG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("min_index_topological_sort: mismatch");
            $finish;
         end
      end
   end

   // Offers one command and holds it until the transfer. Afterwards start
   // either stays high for the next command or drops for a random gap, so it
   // is never lowered and raised within one time step.
   task automatic send_command(logic command, logic [3:0] producer, logic [3:0] consumer);
      mits_pkg::req_type item;
      item.command = command;
      item.producer_index = producer;
      item.consumer_index = consumer;
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stops offering commands and waits until every expected result has
   // transferred, then lets the block settle.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the sorter idle.
   task automatic load_node_count(logic [4:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One well-formed batch: mostly edges that respect a random ranking of the
   // active nodes, so the sort gets deep, plus some noise (self edges, repeats,
   // back edges that close cycles, endpoints outside the active range), and
   // then the run command with random edge fields.
   task automatic send_batch(output int sent);
      int rank [mits_pkg::INDEX_LIMIT];
      int n;
      int edges;
      int a;
      int b;
      int swap;
      int tmp;
      n = (tracker.node_count > mits_pkg::INDEX_LIMIT) ? mits_pkg::INDEX_LIMIT
                                                        : tracker.node_count;
      for (int i = 0; i < mits_pkg::INDEX_LIMIT; i++) rank[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         swap = $urandom_range(i);
         tmp = rank[i];
         rank[i] = rank[swap];
         rank[swap] = tmp;
      end
      edges = ($urandom_range(9) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 10);
      for (int e = 0; e < edges; e++) begin
         if (n >= 2 && $urandom_range(99) < 80) begin
            a = $urandom_range(n - 2);
            b = $urandom_range(a + 1, n - 1);
            send_command(mits_pkg::CMD_ADD_EDGE, 4'(rank[a]), 4'(rank[b]));
         end else begin
            send_command(mits_pkg::CMD_ADD_EDGE, 4'($urandom_range(15)),
                         4'($urandom_range(15)));
         end
      end
      send_command(mits_pkg::CMD_RUN, 4'($urandom_range(15)), 4'($urandom_range(15)));
      sent = edges + 1;
   endtask

   initial begin
      int random_items;
      int sent;
      int pick;
      tracker = new();
      gap_pct = 23;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full store: a repeated edge and a self edge must not disturb the order.
      load_node_count(5'd16);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd15, 4'd0);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd15, 4'd0);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd5, 4'd5);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd3, 4'd1);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd2, 4'd1);
      send_command(mits_pkg::CMD_RUN, 4'd15, 4'd15);
      // A two-node loop leaves nodes behind and must flag a cycle.
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd1, 4'd2);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd2, 4'd1);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd0, 4'd3);
      send_command(mits_pkg::CMD_RUN, 4'd0, 4'd0);
      // No active nodes: only the status result comes back.
      load_node_count(5'd0);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd0, 4'd1);
      send_command(mits_pkg::CMD_RUN, 4'd10, 4'd5);
      // Counts past the store size saturate to a full sort.
      load_node_count(5'd31);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd10, 4'd12);
      send_command(mits_pkg::CMD_RUN, 4'd0, 4'd15);
      // One active node: edges touching inactive nodes are held but ignored.
      load_node_count(5'd1);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd0, 4'd5);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd5, 4'd0);
      send_command(mits_pkg::CMD_RUN, 4'd7, 4'd9);
      load_node_count(5'd17);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd0, 4'd15);
      send_command(mits_pkg::CMD_ADD_EDGE, 4'd15, 4'd14);
      send_command(mits_pkg::CMD_RUN, 4'd3, 4'd12);
      // The sender holds off here until every result of the directed part is in.
      drain_results();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items < RANDOM_ITEMS / 3) gap_pct = 23;
         else if (random_items < 2 * RANDOM_ITEMS / 3) gap_pct = 53;
         else gap_pct = 0;
         if ($urandom_range(1) == 0) begin
            pick = $urandom_range(9);
            if (pick == 0) load_node_count(5'($urandom_range(0, 1)));
            else if (pick == 1) load_node_count(5'($urandom_range(17, 31)));
            else if (pick < 5) load_node_count(5'd16);
            else load_node_count(5'($urandom_range(2, 16)));
         end
         send_batch(sent);
         random_items += sent;
      end

      drain_results();
      if (tracker.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, tracker.pending());
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("min_index_topological_sort: match");
      end else begin
         $display("min_index_topological_sort: mismatch");
      end
      $finish;
   end

endmodule
